// File: hw/rtl/search_deadline_controller_macros.svh
// Assertion helpers for the search deadline controller.
`ifndef SEARCH_DEADLINE_CONTROLLER_MACROS_SVH
`define SEARCH_DEADLINE_CONTROLLER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sdc_pkg.sv
package sdc_pkg;

  // Event codes carried in func
  localparam logic [2:0] FUNC_TICK      = 3'd0;
  localparam logic [2:0] FUNC_ITER_DONE = 3'd1;
  localparam logic [2:0] FUNC_FAIL_LOW  = 3'd2;
  localparam logic [2:0] FUNC_FAIL_HIGH = 3'd3;
  localparam logic [2:0] FUNC_STOP      = 3'd4;
  localparam logic [2:0] FUNC_PONDERHIT = 3'd5;

  // Time control modes (code 3 runs as normal)
  localparam logic [1:0] MODE_UNLIMITED = 2'd0;
  localparam logic [1:0] MODE_FIXED     = 2'd1;
  localparam logic [1:0] MODE_NORMAL    = 2'd2;

  // Register indexes, one 64-bit slot each
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NODE_LIM_ON = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NODE_LIMIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BUDGET     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_TIME   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TIME   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_START_POND = 3'd6;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned NODE_W  = 48;
  // 0.7 of the budget: time*10 >= budget*7
  localparam int unsigned FRAC_W      = TIME_W + 4;
  localparam int unsigned TIME_SCALE  = 10;
  localparam int unsigned BUDGET_FRAC = 7;

  typedef enum logic [3:0] {
    PH_PONDER   = 4'b0001,
    PH_STANDARD = 4'b0010,
    PH_EXTENDED = 4'b0100,
    PH_FINISHED = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              node_limit_on;
    logic [NODE_W-1:0] node_limit;
    logic [TIME_W-1:0] budget_time;
    logic [TIME_W-1:0] min_time;
    logic [TIME_W-1:0] max_time;
  } cfg_t;

  typedef struct packed {
    logic wr;
    logic val;
  } pond_wr_t;

  typedef struct packed {
    logic finished;
  } status_t;

endpackage

// File: hw/rtl/sdc_cfg_regs.sv
module sdc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [sdc_pkg::DATA_W-1:0]  pwdata,
  output logic [sdc_pkg::DATA_W-1:0]  prdata,
  output sdc_pkg::cfg_t               cfg,
  output sdc_pkg::pond_wr_t           pond_wr
);

  logic                            wr_en;
  logic [sdc_pkg::REG_IDX_W-1:0]   reg_idx;
  sdc_pkg::cfg_t                   cfg_r;
  logic                            start_pond_r;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[sdc_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= sdc_pkg::MODE_NORMAL;
      cfg_r.node_limit_on <= 1'b0;
      cfg_r.node_limit    <= '0;
      cfg_r.budget_time   <= '0;
      cfg_r.min_time      <= '0;
      cfg_r.max_time      <= '0;
      start_pond_r        <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sdc_pkg::REG_MODE:        cfg_r.mode          <= pwdata[1:0];
        sdc_pkg::REG_NODE_LIM_ON: cfg_r.node_limit_on <= pwdata[0];
        sdc_pkg::REG_NODE_LIMIT:  cfg_r.node_limit    <= pwdata[sdc_pkg::NODE_W-1:0];
        sdc_pkg::REG_BUDGET:      cfg_r.budget_time   <= pwdata[sdc_pkg::TIME_W-1:0];
        sdc_pkg::REG_MIN_TIME:    cfg_r.min_time      <= pwdata[sdc_pkg::TIME_W-1:0];
        sdc_pkg::REG_MAX_TIME:    cfg_r.max_time      <= pwdata[sdc_pkg::TIME_W-1:0];
        sdc_pkg::REG_START_POND:  start_pond_r        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sdc_pkg::REG_MODE:        prdata = sdc_pkg::DATA_W'(cfg_r.mode);
      sdc_pkg::REG_NODE_LIM_ON: prdata = sdc_pkg::DATA_W'(cfg_r.node_limit_on);
      sdc_pkg::REG_NODE_LIMIT:  prdata = sdc_pkg::DATA_W'(cfg_r.node_limit);
      sdc_pkg::REG_BUDGET:      prdata = sdc_pkg::DATA_W'(cfg_r.budget_time);
      sdc_pkg::REG_MIN_TIME:    prdata = sdc_pkg::DATA_W'(cfg_r.min_time);
      sdc_pkg::REG_MAX_TIME:    prdata = sdc_pkg::DATA_W'(cfg_r.max_time);
      sdc_pkg::REG_START_POND:  prdata = sdc_pkg::DATA_W'(start_pond_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg         = cfg_r;
  // Writing start_pondering also reloads the ponder state in the core
  assign pond_wr.wr  = wr_en && (reg_idx == sdc_pkg::REG_START_POND);
  assign pond_wr.val = pwdata[0];

endmodule

// File: hw/rtl/sdc_core.sv
module sdc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sdc_pkg::cfg_t               cfg,
  input  sdc_pkg::pond_wr_t           pond_wr,
  input  logic                        step,
  input  logic [2:0]                  func,
  input  logic [sdc_pkg::TIME_W-1:0]  elapsed_ms,
  input  logic [sdc_pkg::NODE_W-1:0]  nodes_seen,
  output logic                        stop_nxt,
  output logic                        finished_nxt,
  output sdc_pkg::status_t            status
);

  sdc_pkg::phase_t phase_r, phase_nxt;
  logic stop_req_r, stop_req_nxt;
  logic first_done_r, first_done_nxt;
  logic iter_just_r, iter_just_nxt;
  logic fail_low_r, fail_low_nxt;
  logic fail_high_r, fail_high_nxt;
  logic pond_r, pond_nxt;

  logic [sdc_pkg::FRAC_W-1:0] time_x10;
  logic [sdc_pkg::FRAC_W-1:0] budget_x7;
  logic                       frac_hit;
  logic                       t_ge_min;
  logic                       t_ge_budget;
  logic                       t_ge_max;
  logic                       node_hit;
  logic                       halt;

  assign time_x10    = sdc_pkg::FRAC_W'(elapsed_ms) * sdc_pkg::FRAC_W'(sdc_pkg::TIME_SCALE);
  assign budget_x7   = sdc_pkg::FRAC_W'(cfg.budget_time)
                       * sdc_pkg::FRAC_W'(sdc_pkg::BUDGET_FRAC);
  assign frac_hit    = time_x10 >= budget_x7;
  assign t_ge_min    = elapsed_ms >= cfg.min_time;
  assign t_ge_budget = elapsed_ms >= cfg.budget_time;
  assign t_ge_max    = elapsed_ms >= cfg.max_time;
  assign node_hit    = cfg.node_limit_on && first_done_r && (nodes_seen >= cfg.node_limit);

  always_comb begin
    phase_nxt      = phase_r;
    stop_req_nxt   = stop_req_r;
    first_done_nxt = first_done_r;
    iter_just_nxt  = iter_just_r;
    fail_low_nxt   = fail_low_r;
    fail_high_nxt  = fail_high_r;
    pond_nxt       = pond_r;
    halt           = 1'b0;
    if (step) begin
      unique case (func)
        sdc_pkg::FUNC_TICK: begin
          unique case (cfg.mode)
            sdc_pkg::MODE_UNLIMITED: begin
              halt = stop_req_r || node_hit;
              if (halt) phase_nxt = sdc_pkg::PH_FINISHED;
            end
            sdc_pkg::MODE_FIXED: begin
              halt = stop_req_r || (t_ge_budget && first_done_r);
              if (halt) phase_nxt = sdc_pkg::PH_FINISHED;
            end
            default: begin
              unique case (phase_r)
                sdc_pkg::PH_STANDARD: begin
                  if (stop_req_r || (iter_just_r && t_ge_min && frac_hit)) begin
                    phase_nxt = sdc_pkg::PH_FINISHED;
                    halt      = 1'b1;
                  end else if (t_ge_budget) begin
                    if (fail_low_r || fail_high_r) begin
                      phase_nxt = sdc_pkg::PH_EXTENDED;
                    end else if (first_done_r) begin
                      phase_nxt = sdc_pkg::PH_FINISHED;
                      halt      = 1'b1;
                    end
                  end
                end
                sdc_pkg::PH_PONDER: begin
                  if (stop_req_r) begin
                    phase_nxt = sdc_pkg::PH_FINISHED;
                    halt      = 1'b1;
                  end else if (!pond_r) begin
                    phase_nxt = sdc_pkg::PH_STANDARD;
                  end
                end
                sdc_pkg::PH_EXTENDED: begin
                  if (stop_req_r || (t_ge_max && first_done_r) || iter_just_r) begin
                    phase_nxt = sdc_pkg::PH_FINISHED;
                    halt      = 1'b1;
                  end
                end
                default: halt = 1'b1;
              endcase
            end
          endcase
          iter_just_nxt = 1'b0;
        end
        sdc_pkg::FUNC_ITER_DONE: begin
          first_done_nxt = 1'b1;
          iter_just_nxt  = 1'b1;
          fail_low_nxt   = 1'b0;
          fail_high_nxt  = 1'b0;
        end
        sdc_pkg::FUNC_FAIL_LOW: begin
          fail_low_nxt  = 1'b1;
          fail_high_nxt = 1'b0;
        end
        sdc_pkg::FUNC_FAIL_HIGH: begin
          fail_low_nxt  = 1'b0;
          fail_high_nxt = 1'b1;
        end
        sdc_pkg::FUNC_STOP:      stop_req_nxt = 1'b1;
        sdc_pkg::FUNC_PONDERHIT: pond_nxt     = 1'b0;
        default: ;
      endcase
    end else if (pond_wr.wr) begin
      pond_nxt = pond_wr.val;
      if (phase_r == sdc_pkg::PH_PONDER || phase_r == sdc_pkg::PH_STANDARD) begin
        phase_nxt = pond_wr.val ? sdc_pkg::PH_PONDER : sdc_pkg::PH_STANDARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdc_pkg::PH_STANDARD;
      stop_req_r   <= 1'b0;
      first_done_r <= 1'b0;
      iter_just_r  <= 1'b0;
      fail_low_r   <= 1'b0;
      fail_high_r  <= 1'b0;
      pond_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      stop_req_r   <= stop_req_nxt;
      first_done_r <= first_done_nxt;
      iter_just_r  <= iter_just_nxt;
      fail_low_r   <= fail_low_nxt;
      fail_high_r  <= fail_high_nxt;
      pond_r       <= pond_nxt;
    end
  end

  assign stop_nxt        = halt;
  assign finished_nxt    = (phase_nxt == sdc_pkg::PH_FINISHED);
  assign status.finished = (phase_r == sdc_pkg::PH_FINISHED);

endmodule

// File: hw/rtl/search_deadline_controller.sv
// Search deadline controller: tells an iterative-deepening search when to stop.
// Input channel (in_valid/in_stall): one event item per handshake - tick with
// elapsed ms and node count, iteration done, fail low, fail high, stop request
// or ponder hit. Every item yields exactly one result item on the output
// channel (out_valid/out_stall): out_stop_search and out_finished.
// Path: an accepted item is captured in the input register, is evaluated
// against the controller state and lands in the result register once that
// register is empty or drains; out_valid follows the result register.
// Throughput: one item per cycle while the receiver does not stall; the limit is
// the single state update per cycle between the input and result registers.
// When the receiver stalls, the result holds and one more item is taken into
// the input register; in_stall rises only when both registers are full.
// Reset (rst_n low at a clock edge, synchronous) empties both registers, loads
// the register defaults (normal mode, all times zero) and the standard phase.
// Configuration is an APB-style port with 64-bit registers at 8*index; write
// it only while no item is in flight.
`include "search_deadline_controller_macros.svh"

module search_deadline_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  // event input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_func,
  input  logic [sdc_pkg::TIME_W-1:0]  in_elapsed_ms,
  input  logic [sdc_pkg::NODE_W-1:0]  in_nodes_seen,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_stop_search,
  output logic                        out_finished,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [sdc_pkg::DATA_W-1:0]  pwdata,
  output logic [sdc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  sdc_pkg::cfg_t      cfg;
  sdc_pkg::pond_wr_t  pond_wr;
  sdc_pkg::status_t   status;

  // input register
  logic                        in_valid_r;
  logic [2:0]                  func_r;
  logic [sdc_pkg::TIME_W-1:0]  elapsed_r;
  logic [sdc_pkg::NODE_W-1:0]  nodes_r;

  // result register
  logic out_valid_r;
  logic stop_r;
  logic finished_r;

  logic advance;    // input register item moves into the result register
  logic stop_nxt;
  logic finished_nxt;

  assign pready   = 1'b1;
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  // input register can take an item when empty or when it drains this cycle
  assign in_stall = in_valid_r && !advance;

  sdc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .pond_wr (pond_wr)
  );

  sdc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .pond_wr      (pond_wr),
    .step         (advance),
    .func         (func_r),
    .elapsed_ms   (elapsed_r),
    .nodes_seen   (nodes_r),
    .stop_nxt     (stop_nxt),
    .finished_nxt (finished_nxt),
    .status       (status)
  );

  // input register: control reset, payload loads on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r    <= in_func;
      elapsed_r <= in_elapsed_ms;
      nodes_r   <= in_nodes_seen;
    end
  end

  // result register: filled on advance, held while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stop_r     <= stop_nxt;
      finished_r <= finished_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stop_search = stop_r;
  assign out_finished    = finished_r;

  // finished is terminal until reset
  `SDC_ASSERT_NEXT(a_finished_sticky, clk, rst_n, status.finished, status.finished, "finished phase left")
  // a stop is only ever issued together with the finished phase
  `SDC_ASSERT_NOW(a_stop_implies_fin, clk, rst_n, out_valid && out_stop_search, out_finished, "stop result without finished")
  // once finished, every later result reports it
  `SDC_ASSERT_NEXT(a_fin_reported, clk, rst_n, status.finished && advance, out_valid && out_finished, "finished not reported")

endmodule
